### src/phb_pkg.sv
// Shared types and constants for the particle histogram binner.
// Used by phb_calc, phb_mem and particle_histogram_binner_top.
`default_nettype none

package phb_pkg;

  localparam int MAX_BINS  = 4096;
  localparam int BIN_W     = $clog2(MAX_BINS);
  localparam int COUNT_W   = 32;
  localparam int POS_W     = 32;
  localparam int SCALE_W   = 32;
  localparam int NBINS_W   = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  // Input commands
  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_SCALE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT  = 2'd3;

  // Register reset values
  localparam logic signed [POS_W-1:0] RANGE_LOW_RST  = 32'sh0000_0000;
  localparam logic signed [POS_W-1:0] RANGE_HIGH_RST = 32'sh1000_0000;
  localparam logic [SCALE_W-1:0]      BIN_SCALE_RST  = 32'h0001_0000;
  localparam logic [NBINS_W-1:0]      BIN_COUNT_RST  = 13'd4096;

  typedef struct packed {
    logic                    command;
    logic signed [POS_W-1:0] position;
    logic [BIN_W-1:0]        bin_index;
  } hist_in_t;

  typedef struct packed {
    logic [BIN_W-1:0]   bin;
    logic [COUNT_W-1:0] count;
    logic               in_range;
  } hist_out_t;

  // Bin computation result handed to the control FSM
  typedef struct packed {
    logic             valid;
    logic             in_range;
    logic [BIN_W-1:0] bin;
  } calc_res_t;

  // Memory access request from the control FSM
  typedef struct packed {
    logic               rd_en;
    logic [BIN_W-1:0]   rd_addr;
    logic               wr_en;
    logic [BIN_W-1:0]   wr_addr;
    logic [COUNT_W-1:0] wr_data;
  } mem_req_t;

endpackage

`default_nettype wire

### src/phb_calc.sv
// Three-stage bin index pipeline: range check and offset, Q32.32 product,
// clamp to the last bin in use. Depends on phb_pkg.
`default_nettype none

module phb_calc (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [phb_pkg::POS_W-1:0]  position_i,
  input  logic signed [phb_pkg::POS_W-1:0]  range_low_i,
  input  logic signed [phb_pkg::POS_W-1:0]  range_high_i,
  input  logic [phb_pkg::SCALE_W-1:0]       bin_scale_i,
  input  logic [phb_pkg::BIN_W-1:0]         last_bin_i,
  output phb_pkg::calc_res_t                res_o
);
  import phb_pkg::*;

  localparam int PROD_W = POS_W + SCALE_W;
  localparam int IDX_W  = PROD_W - 32;

  logic             s1_valid_q, s2_valid_q, s3_valid_q;
  logic             s1_ok_q, s2_ok_q, s3_ok_q;
  logic [POS_W-1:0] diff_d, diff_q;
  logic             ok_d;
  logic [PROD_W-1:0] prod_d, prod_q;
  logic [IDX_W-1:0] idx;
  logic [BIN_W-1:0] bin_d, bin_q;

  // Difference is only meaningful when in range, where it fits 32 unsigned bits
  assign ok_d   = (position_i >= range_low_i) && (position_i <= range_high_i);
  assign diff_d = POS_W'(position_i - range_low_i);

  assign prod_d = PROD_W'(diff_q) * PROD_W'(bin_scale_i);

  // Clamp anything past the last bin, including a position at the upper cut
  assign idx   = prod_q[PROD_W-1:32];
  assign bin_d = (idx > IDX_W'(last_bin_i)) ? last_bin_i : idx[BIN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q  <= diff_d;
    s1_ok_q <= ok_d;
    prod_q  <= prod_d;
    s2_ok_q <= s1_ok_q;
    bin_q   <= bin_d;
    s3_ok_q <= s2_ok_q;
  end

  assign res_o.valid    = s3_valid_q;
  assign res_o.in_range = s3_ok_q;
  assign res_o.bin      = bin_q;

endmodule

`default_nettype wire

### src/phb_mem.sv
// Bin count store: one synchronous memory with a registered read port and a
// zeroing sweep after reset. Depends on phb_pkg.
`default_nettype none

module phb_mem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  phb_pkg::mem_req_t             req_i,
  output logic [phb_pkg::COUNT_W-1:0]   rd_data_o,
  output logic                          busy_o
);
  import phb_pkg::*;

  logic [COUNT_W-1:0] counts_q [MAX_BINS];
  logic [COUNT_W-1:0] rd_data_q;
  logic [BIN_W:0]     clr_cnt_d, clr_cnt_q;
  logic               wr_en;
  logic [BIN_W-1:0]   wr_addr;
  logic [COUNT_W-1:0] wr_data;

  // Sweep runs until the counter reaches the depth
  assign busy_o    = !clr_cnt_q[BIN_W];
  assign clr_cnt_d = busy_o ? clr_cnt_q + 1'b1 : clr_cnt_q;

  assign wr_en   = busy_o || req_i.wr_en;
  assign wr_addr = busy_o ? clr_cnt_q[BIN_W-1:0] : req_i.wr_addr;
  assign wr_data = busy_o ? '0 : req_i.wr_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      counts_q[wr_addr] <= wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= counts_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### src/particle_histogram_binner_top.sv
// Particle histogram binner top level: configuration registers, control FSM,
// output register. Depends on phb_pkg, phb_calc and phb_mem.
`default_nettype none

// Bins signed Q16.16 positions into up to 4096 uniform bins of 32-bit
// saturating counts, and reads out and clears single bins on request. One
// item is in flight at a time. A read command reads the memory at its
// transfer and has its result registered from the update state, after which
// the block returns to idle and can take a new transfer. An accumulate passes
// through the bin index pipeline with its 32x32 multiplier (the transfer edge
// loads the first stage), then the memory read, then the write-back, which is
// made as its result is registered; the block then returns to idle. While a
// full output register stays stalled, the block waits in the update state
// before the result is registered. A new item is taken while the previous
// result still sits in the output register. After reset the block zeroes its
// count memory and stalls input meanwhile; configuration writes are taken at
// any time but must only be made while the block is idle.
module particle_histogram_binner_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  phb_pkg::hist_in_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output phb_pkg::hist_out_t               out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [phb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [phb_pkg::CFG_W-1:0]        cfg_data_i
);
  import phb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_UPD  = 3'b100
  } state_e;

  state_e state_d, state_q;

  logic signed [POS_W-1:0] range_low_q, range_high_q;
  logic [SCALE_W-1:0]      bin_scale_q;
  logic [NBINS_W-1:0]      bin_count_q;
  logic [BIN_W-1:0]        last_bin;
  logic                    cfg_wr;

  logic                    in_xfer, calc_start, mem_busy;
  calc_res_t               calc_res;
  mem_req_t                mem_req;
  logic [COUNT_W-1:0]      rd_data, sat_count;

  logic                    cmd_d, cmd_q, ok_d, ok_q;
  logic [BIN_W-1:0]        bin_d, bin_q;
  logic                    load_out;
  logic                    out_valid_d, out_valid_q;
  hist_out_t               out_d, out_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q  <= RANGE_LOW_RST;
      range_high_q <= RANGE_HIGH_RST;
      bin_scale_q  <= BIN_SCALE_RST;
      bin_count_q  <= BIN_COUNT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        CFG_RANGE_LOW:  range_low_q  <= cfg_data_i;
        CFG_RANGE_HIGH: range_high_q <= cfg_data_i;
        CFG_BIN_SCALE:  bin_scale_q  <= cfg_data_i;
        CFG_BIN_COUNT:  bin_count_q  <= cfg_data_i[NBINS_W-1:0];
        default: ;
      endcase
    end
  end

  // Last bin in use: zero bins counts as one, too many as the maximum
  always_comb begin
    if (bin_count_q == '0) begin
      last_bin = '0;
    end else if (bin_count_q > NBINS_W'(MAX_BINS)) begin
      last_bin = BIN_W'(MAX_BINS - 1);
    end else begin
      last_bin = BIN_W'(bin_count_q - 1'b1);
    end
  end

  assign in_stall_o = mem_busy || (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign calc_start = in_xfer && (in_data_i.command == CMD_ACCUM);

  phb_calc u_calc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (calc_start),
    .position_i   (in_data_i.position),
    .range_low_i  (range_low_q),
    .range_high_i (range_high_q),
    .bin_scale_i  (bin_scale_q),
    .last_bin_i   (last_bin),
    .res_o        (calc_res)
  );

  phb_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_data),
    .busy_o    (mem_busy)
  );

  // Hold at the counter maximum
  assign sat_count = (rd_data == '1) ? rd_data : rd_data + 1'b1;

  // Only one item is in flight, so a write-back always lands before the next read
  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    ok_d     = ok_q;
    bin_d    = bin_q;
    load_out = 1'b0;
    mem_req  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_d = in_data_i.command;
          if (in_data_i.command == CMD_READ) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = in_data_i.bin_index;
            ok_d            = in_data_i.bin_index <= last_bin;
            bin_d           = in_data_i.bin_index;
            state_d         = S_UPD;
          end else begin
            state_d = S_CALC;
          end
        end
      end
      S_CALC: begin
        if (calc_res.valid) begin
          mem_req.rd_en   = calc_res.in_range;
          mem_req.rd_addr = calc_res.bin;
          ok_d            = calc_res.in_range;
          bin_d           = calc_res.in_range ? calc_res.bin : '0;
          state_d         = S_UPD;
        end
      end
      S_UPD: begin
        // Wait for the output register to free up
        if (!out_valid_q || !out_stall_i) begin
          load_out        = 1'b1;
          mem_req.wr_en   = ok_q;
          mem_req.wr_addr = bin_q;
          mem_req.wr_data = (cmd_q == CMD_READ) ? '0 : sat_count;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_d.bin      = bin_q;
    out_d.in_range = ok_q;
    if (!ok_q) begin
      out_d.count = '0;
    end else if (cmd_q == CMD_READ) begin
      out_d.count = rd_data;
    end else begin
      out_d.count = sat_count;
    end
  end

  assign out_valid_d = load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    ok_q  <= ok_d;
    bin_q <= bin_d;
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
